>>> rtl/pbr_pkg.sv
// ---------------------------------------------------------------------------
// pbr_pkg
// Shared types, constants and helpers of the polynomial bisection root core.
// ---------------------------------------------------------------------------
package pbr_pkg;

    localparam int MAX_TERMS  = 16;
    localparam int FRAC_BITS  = 20;
    localparam int ADDR_W     = $clog2(MAX_TERMS);
    localparam int IDX_W      = 4;
    localparam int WORD_W     = 32;
    localparam int TOL_W      = 16;
    localparam int LIM_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 2'd2;

    // word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_EXACT_A   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXACT_B   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SAME_SIGN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXACT_MID = 3'd3;
    localparam logic [STATUS_W-1:0] ST_APPROX    = 3'd4;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         coef_index;
        logic signed [WORD_W-1:0] coef_value;
        logic signed [WORD_W-1:0] left_end;
        logic signed [WORD_W-1:0] right_end;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] root;
        logic [STATUS_W-1:0]      status;
        logic [LIM_W-1:0]         steps_taken;
        logic                     saturated;
    } res_t;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] x;
    } eval_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] value;
        logic                     sat;
    } eval_rsp_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W+IDX_W-1:0] wide;
        wide = {{ADDR_W{1'b0}}, idx};
        return wide[ADDR_W-1:0];
    endfunction

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        logic [ADDR_W+IDX_W-1:0] wide;
        wide = {{ADDR_W{1'b0}}, idx};
        return wide < (ADDR_W+IDX_W)'(MAX_TERMS);
    endfunction

endpackage

>>> rtl/pbr_coef_ram.sv
// ---------------------------------------------------------------------------
// pbr_coef_ram
// Coefficient store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pbr_coef_ram
    import pbr_pkg::*;
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [WORD_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [WORD_W-1:0] rd_data
);

    logic signed [WORD_W-1:0] mem [MAX_TERMS];
    logic signed [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/pbr_horner.sv
// ---------------------------------------------------------------------------
// pbr_horner
// Horner evaluator: one shared 32x32 multiplier, coefficients read from the
// store one per step, round half up and saturate after each step.
// ---------------------------------------------------------------------------
module pbr_horner
    import pbr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IDX_W-1:0]         degree,
    input  eval_req_t                req,
    output eval_rsp_t                rsp,
    output logic                     rd_en,
    output logic [ADDR_W-1:0]        rd_addr,
    input  logic signed [WORD_W-1:0] rd_data
);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_LOAD = 3'd1;
    localparam logic [2:0] H_MUL  = 3'd2;
    localparam logic [2:0] H_ADD  = 3'd3;
    localparam logic [2:0] H_DONE = 3'd4;

    localparam logic signed [2*WORD_W-1:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [2*WORD_W:0]   SUM_HI = 65'sd2147483647;
    localparam logic signed [2*WORD_W:0]   SUM_LO = -65'sd2147483648;

    logic [2:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           step_reg, step_next;
    logic                       sat_reg, sat_next;
    logic signed [WORD_W-1:0]   x_reg, x_next;
    logic signed [WORD_W-1:0]   acc_reg, acc_next;
    logic signed [2*WORD_W-1:0] prod_reg, prod_next;

    logic signed [2*WORD_W-1:0] shifted;
    logic signed [WORD_W-1:0]   coef_term;
    logic signed [2*WORD_W:0]   sum;
    logic                       can_start;

    assign can_start = (state_reg == H_IDLE) || (state_reg == H_DONE);
    assign shifted   = (prod_reg + HALF) >>> FRAC_BITS;
    assign coef_term = idx_in_range(step_reg) ? rd_data : '0;
    assign sum       = (2*WORD_W+1)'(shifted) + (2*WORD_W+1)'(coef_term);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sat_next   = sat_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        rd_en      = 1'b0;
        rd_addr    = to_addr(step_reg);
        case (state_reg)
            H_IDLE, H_DONE:
            begin
                if (req.start)
                begin
                    x_next     = req.x;
                    sat_next   = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = H_LOAD;
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            H_LOAD:
            begin
                acc_next   = rd_data;
                step_next  = IDX_W'(1);
                state_next = (degree == '0) ? H_DONE : H_MUL;
            end
            H_MUL:
            begin
                prod_next  = acc_reg * x_reg;
                rd_en      = idx_in_range(step_reg);
                state_next = H_ADD;
            end
            H_ADD:
            begin
                if (sum > SUM_HI)
                begin
                    acc_next = SUM_HI[WORD_W-1:0];
                    sat_next = 1'b1;
                end
                else if (sum < SUM_LO)
                begin
                    acc_next = SUM_LO[WORD_W-1:0];
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = sum[WORD_W-1:0];
                end
                if (step_reg == degree)
                begin
                    state_next = H_DONE;
                end
                else
                begin
                    step_next  = step_reg + IDX_W'(1);
                    state_next = H_MUL;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            step_reg  <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign rsp.done  = (state_reg == H_DONE) && !can_start ? 1'b0 : (state_reg == H_DONE);
    assign rsp.value = acc_reg;
    assign rsp.sat   = sat_reg;

endmodule

>>> rtl/polynomial_bisection_root_core.sv
// ---------------------------------------------------------------------------
// polynomial_bisection_root_core
// Bisection root finder for a fixed-point polynomial held in a small store.
// ---------------------------------------------------------------------------
// A load word (kind 0) writes one Q12.20 coefficient, highest power at index
// 0, and returns nothing. A solve word (kind 1) evaluates p(a) and p(b),
// then bisects unless the end values decide, and returns one result word.
// Each evaluation runs through the shared Horner unit: it loads the first
// coefficient, then does one 32x32 multiply and one round/add/saturate per
// further coefficient, with coefficients read from the store through its
// registered read port. A solve takes at most iteration_limit bisection
// steps; a result still waiting on the output holds the core until it is
// taken. The coefficient store comes up undefined: write every coefficient
// up to the configured degree before solving. Configuration registers
// (degree, tolerance, iteration limit) are to be written by the user only
// while the core is idle; the core itself does not enforce this.
// ---------------------------------------------------------------------------
module polynomial_bisection_root_core
    import pbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL_A = 3'd1;
    localparam logic [2:0] S_EVAL_B = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_LOOP   = 3'd4;
    localparam logic [2:0] S_EVAL_C = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [IDX_W-1:0]         degree_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic [LIM_W-1:0]         limit_reg;

    logic [2:0]               state_reg, state_next;
    logic                     res_valid_reg, res_valid_next;
    logic                     sat_reg, sat_next;
    logic [LIM_W-1:0]         steps_reg, steps_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [WORD_W-1:0] a_reg, a_next;
    logic signed [WORD_W-1:0] b_reg, b_next;
    logic signed [WORD_W-1:0] fa_reg, fa_next;
    logic signed [WORD_W-1:0] fb_reg, fb_next;
    logic signed [WORD_W-1:0] root_reg, root_next;
    res_t                     res_reg, res_next;

    eval_req_t                eval_req;
    eval_rsp_t                eval_rsp;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [WORD_W-1:0] rd_data;
    logic                     cmd_fire;
    logic                     ram_we;

    logic signed [WORD_W:0]   sum_ab;
    logic signed [WORD_W-1:0] mid;
    logic signed [WORD_W:0]   width;
    logic                     fa_pos, fa_neg, fb_pos, fb_neg, fc_pos, fc_neg;

    function automatic logic below_tol(input logic signed [WORD_W-1:0] v,
                                       input logic [TOL_W-1:0] t);
        logic signed [WORD_W+1:0] wv;
        logic signed [WORD_W+1:0] wt;
        wv = (WORD_W+2)'(v);
        wt = (WORD_W+2)'({1'b0, t});
        return (wv < wt) && (wv > -wt);
    endfunction

    function automatic logic above_tol(input logic signed [WORD_W:0] v,
                                       input logic [TOL_W-1:0] t);
        logic signed [WORD_W+1:0] wv;
        logic signed [WORD_W+1:0] wt;
        wv = (WORD_W+2)'(v);
        wt = (WORD_W+2)'({1'b0, t});
        return (wv > wt) || (wv < -wt);
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign ram_we    = cmd_fire && (cmd.kind == KIND_LOAD) && idx_in_range(cmd.coef_index);

    // floor((a+b)/2) is exact in 33 bits
    assign sum_ab = (WORD_W+1)'(a_reg) + (WORD_W+1)'(b_reg);
    assign mid    = sum_ab[WORD_W:1];
    assign width  = (WORD_W+1)'(b_reg) - (WORD_W+1)'(a_reg);

    assign fa_neg = fa_reg[WORD_W-1];
    assign fa_pos = !fa_reg[WORD_W-1] && (fa_reg != '0);
    assign fb_neg = fb_reg[WORD_W-1];
    assign fb_pos = !fb_reg[WORD_W-1] && (fb_reg != '0);
    assign fc_neg = eval_rsp.value[WORD_W-1];
    assign fc_pos = !eval_rsp.value[WORD_W-1] && (eval_rsp.value != '0);

    pbr_coef_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (to_addr(cmd.coef_index)),
        .wr_data (cmd.coef_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pbr_horner u_horner (
        .clk     (clk),
        .rst_n   (rst_n),
        .degree  (degree_reg),
        .req     (eval_req),
        .rsp     (eval_rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        sat_next       = sat_reg;
        steps_next     = steps_reg;
        status_next    = status_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        root_next      = root_reg;
        res_next       = res_reg;
        eval_req.start = 1'b0;
        eval_req.x     = a_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && (cmd.kind == KIND_SOLVE))
                begin
                    a_next         = cmd.left_end;
                    b_next         = cmd.right_end;
                    sat_next       = 1'b0;
                    steps_next     = '0;
                    root_next      = '0;
                    eval_req.start = 1'b1;
                    eval_req.x     = cmd.left_end;
                    state_next     = S_EVAL_A;
                end
            end
            S_EVAL_A:
            begin
                if (eval_rsp.done)
                begin
                    fa_next        = eval_rsp.value;
                    sat_next       = sat_reg | eval_rsp.sat;
                    eval_req.start = 1'b1;
                    eval_req.x     = b_reg;
                    state_next     = S_EVAL_B;
                end
            end
            S_EVAL_B:
            begin
                if (eval_rsp.done)
                begin
                    fb_next    = eval_rsp.value;
                    sat_next   = sat_reg | eval_rsp.sat;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (below_tol(fa_reg, tol_reg))
                begin
                    status_next = ST_EXACT_A;
                    root_next   = a_reg;
                    state_next  = S_EMIT;
                end
                else if (below_tol(fb_reg, tol_reg))
                begin
                    status_next = ST_EXACT_B;
                    root_next   = b_reg;
                    state_next  = S_EMIT;
                end
                else if ((fa_pos && fb_pos) || (fa_neg && fb_neg))
                begin
                    status_next = ST_SAME_SIGN;
                    state_next  = S_EMIT;
                end
                else
                begin
                    status_next = ST_APPROX;
                    state_next  = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (above_tol(width, tol_reg) && (steps_reg < limit_reg))
                begin
                    root_next      = mid;
                    eval_req.start = 1'b1;
                    eval_req.x     = mid;
                    state_next     = S_EVAL_C;
                end
                else
                begin
                    root_next  = mid;
                    state_next = S_EMIT;
                end
            end
            S_EVAL_C:
            begin
                // root_reg holds the midpoint under evaluation
                if (eval_rsp.done)
                begin
                    sat_next   = sat_reg | eval_rsp.sat;
                    steps_next = steps_reg + LIM_W'(1);
                    if (below_tol(eval_rsp.value, tol_reg))
                    begin
                        status_next = ST_EXACT_MID;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        if ((fa_pos && fc_neg) || (fa_neg && fc_pos))
                        begin
                            b_next = root_reg;
                        end
                        else
                        begin
                            a_next  = root_reg;
                            fa_next = eval_rsp.value;
                        end
                        state_next = S_LOOP;
                    end
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    res_next.root        = root_reg;
                    res_next.status      = status_reg;
                    res_next.steps_taken = steps_reg;
                    res_next.saturated   = sat_reg;
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            degree_reg    <= '0;
            tol_reg       <= TOL_W'(1);
            limit_reg     <= LIM_W'(100);
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEGREE:    degree_reg <= cfg_data[IDX_W-1:0];
                    REG_TOLERANCE: tol_reg    <= cfg_data[TOL_W-1:0];
                    REG_ITER_LIM:  limit_reg  <= cfg_data[LIM_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg    <= sat_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        root_reg   <= root_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
